// ===== rtl/core/rbd_pkg.sv =====
// Shared constants, types and helpers of the RGB565 box downscaler.
`default_nettype none

package rbd_pkg;

   localparam int MAX_WIDTH = 2048;
   localparam int MAX_SCALE = 16;

   localparam int DIM_W   = 12;
   localparam int DIM_MAX = 2048;
   localparam int OW_MAX  = (MAX_WIDTH < DIM_MAX) ? MAX_WIDTH : DIM_MAX;
   localparam int IN_W    = $clog2(DIM_MAX);
   localparam int COL_W   = $clog2(MAX_WIDTH);

   localparam int SUB_W   = (MAX_SCALE > 1) ? $clog2(MAX_SCALE) : 1;
   localparam int SCALE_W = SUB_W + 1;
   localparam int AREA_W  = $clog2(MAX_SCALE * MAX_SCALE + 1);

   localparam int PIX_W     = 16;
   localparam int RED_W     = 5;
   localparam int GREEN_W   = 6;
   localparam int BLUE_W    = 5;
   localparam int RED_LSB   = 11;
   localparam int GREEN_LSB = 5;

   localparam int SUM_R_W = $clog2(((1 << RED_W) - 1) * MAX_SCALE * MAX_SCALE + 1);
   localparam int SUM_G_W = $clog2(((1 << GREEN_W) - 1) * MAX_SCALE * MAX_SCALE + 1);
   localparam int SUM_B_W = $clog2(((1 << BLUE_W) - 1) * MAX_SCALE * MAX_SCALE + 1);
   localparam int SUM_W   = SUM_R_W + SUM_G_W + SUM_B_W;

   localparam int CSR_W     = 2;
   localparam logic [CSR_W-1:0] CSR_INPUT_WIDTH   = 2'd0;
   localparam logic [CSR_W-1:0] CSR_INPUT_HEIGHT  = 2'd1;
   localparam logic [CSR_W-1:0] CSR_OUTPUT_WIDTH  = 2'd2;
   localparam logic [CSR_W-1:0] CSR_OUTPUT_HEIGHT = 2'd3;

   localparam logic [DIM_W-1:0] IW_RESET = DIM_W'(640);
   localparam logic [DIM_W-1:0] IH_RESET = DIM_W'(480);
   localparam logic [DIM_W-1:0] OW_RESET = DIM_W'(240);
   localparam logic [DIM_W-1:0] OH_RESET = DIM_W'(240);

   typedef struct packed {
      logic                busy;
      logic [SCALE_W-1:0]  sx;
      logic [SCALE_W-1:0]  sy;
      logic [AREA_W-1:0]   area;
   } scale_type;

   typedef struct packed {
      logic [SUM_R_W-1:0]  sum_r;
      logic [SUM_G_W-1:0]  sum_g;
      logic [SUM_B_W-1:0]  sum_b;
      logic [AREA_W-1:0]   area;
      logic                row_end;
      logic                frame_end;
   } div_req_type;

   typedef struct packed {
      logic [PIX_W-1:0]    pixel;
      logic                row_end;
      logic                frame_end;
   } div_rsp_type;

   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                  input logic [DIM_W-1:0] hi);
      logic [DIM_W-1:0] r;
      r = v;
      if (v == '0) begin
         r = DIM_W'(1);
      end else if (v > hi) begin
         r = hi;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/rbd_band_ram.sv =====
// Line store of per-column channel sums, one write and one registered read port.
`default_nettype none

module rbd_band_ram
   import rbd_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             rd_en,
   input  wire logic [COL_W-1:0] rd_addr,
   output logic      [SUM_W-1:0] rd_data,
   input  wire logic             wr_en,
   input  wire logic [COL_W-1:0] wr_addr,
   input  wire logic [SUM_W-1:0] wr_data
);

   logic [SUM_W-1:0] mem [MAX_WIDTH];
   logic [SUM_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/core/rbd_scale_calc.sv =====
// Scale factor and block area computation, one quotient bit per cycle.
`default_nettype none

module rbd_scale_calc
   import rbd_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [DIM_W-1:0] iw,
   input  wire logic [DIM_W-1:0] ih,
   input  wire logic [DIM_W-1:0] ow,
   input  wire logic [DIM_W-1:0] oh,
   output scale_type             scale
);

   localparam int STEP_W = (SUB_W > 1) ? $clog2(SUB_W) : 1;
   localparam int WIDE_W = DIM_W + SCALE_W;

   logic               pend_ff;
   logic               run_ff;
   logic               fin_ff;
   logic [STEP_W-1:0]  step_ff;
   logic [DIM_W-1:0]   rem_x_ff, rem_y_ff;
   logic [SUB_W-1:0]   q_x_ff, q_y_ff;
   logic               sat_x_ff, sat_y_ff;
   logic [SCALE_W-1:0] sx_ff, sy_ff;
   logic [AREA_W-1:0]  area_ff;

   logic               load;
   logic [WIDE_W-1:0]  dvs_x, dvs_y;
   logic               ge_x, ge_y;
   logic [SCALE_W-1:0] sx_c, sy_c;
   logic [2*SCALE_W-1:0] area_c;

   // a register write lands at the start edge; the new value is loaded in the cycle after
   assign load = pend_ff;

   always_comb begin
      dvs_x = WIDE_W'(ow) << step_ff;
      dvs_y = WIDE_W'(oh) << step_ff;
      ge_x  = WIDE_W'(rem_x_ff) >= dvs_x;
      ge_y  = WIDE_W'(rem_y_ff) >= dvs_y;
      sx_c  = sat_x_ff ? SCALE_W'(MAX_SCALE) :
              (q_x_ff == '0) ? SCALE_W'(1) : {1'b0, q_x_ff};
      sy_c  = sat_y_ff ? SCALE_W'(MAX_SCALE) :
              (q_y_ff == '0) ? SCALE_W'(1) : {1'b0, q_y_ff};
      area_c = sx_c * sy_c;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 1'b1;
         run_ff  <= 1'b0;
         fin_ff  <= 1'b0;
      end else begin
         pend_ff <= start;
         if (load) begin
            run_ff <= 1'b1;
            fin_ff <= 1'b0;
         end else if (run_ff && step_ff == '0) begin
            run_ff <= 1'b0;
            fin_ff <= 1'b1;
         end else if (fin_ff) begin
            fin_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rem_x_ff <= iw;
         rem_y_ff <= ih;
         q_x_ff   <= '0;
         q_y_ff   <= '0;
         sat_x_ff <= WIDE_W'(iw) >= WIDE_W'(ow) * WIDE_W'(MAX_SCALE);
         sat_y_ff <= WIDE_W'(ih) >= WIDE_W'(oh) * WIDE_W'(MAX_SCALE);
         step_ff  <= STEP_W'(SUB_W - 1);
      end else if (run_ff) begin
         if (ge_x) begin
            rem_x_ff        <= rem_x_ff - dvs_x[DIM_W-1:0];
            q_x_ff[step_ff] <= 1'b1;
         end
         if (ge_y) begin
            rem_y_ff        <= rem_y_ff - dvs_y[DIM_W-1:0];
            q_y_ff[step_ff] <= 1'b1;
         end
         if (step_ff != '0) begin
            step_ff <= step_ff - STEP_W'(1);
         end
      end
      if (fin_ff) begin
         sx_ff   <= sx_c;
         sy_ff   <= sy_c;
         area_ff <= area_c[AREA_W-1:0];
      end
   end

   assign scale.busy = pend_ff || run_ff || fin_ff;
   assign scale.sx   = sx_ff;
   assign scale.sy   = sy_ff;
   assign scale.area = area_ff;

endmodule

`default_nettype wire

// ===== rtl/core/rbd_avg_div.sv =====
// Iterative divider of the three channel sums by the block area, two bits per cycle.
`default_nettype none

module rbd_avg_div
   import rbd_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire div_req_type req,
   input  wire logic        take,
   output logic             busy,
   output logic             done,
   output div_rsp_type      rsp
);

   localparam int SW        = (SUM_G_W > SUM_R_W) ?
                              ((SUM_G_W > SUM_B_W) ? SUM_G_W : SUM_B_W) :
                              ((SUM_R_W > SUM_B_W) ? SUM_R_W : SUM_B_W);
   localparam int DIV_STEPS = (SW + 1) / 2;
   localparam int QW        = 2 * DIV_STEPS;
   localparam int ACC_W     = AREA_W + 1;
   localparam int CNT_W     = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

   logic              run_ff, done_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic [AREA_W-1:0] d_ff;
   logic [ACC_W-1:0]  acc_r_ff, acc_g_ff, acc_b_ff;
   logic [QW-1:0]     q_r_ff, q_g_ff, q_b_ff;
   logic              row_end_ff, frame_end_ff;

   logic [ACC_W+QW-1:0] nxt_r, nxt_g, nxt_b;

   function automatic logic [ACC_W+QW-1:0] div_bit(input logic [ACC_W-1:0]  acc,
                                                   input logic [QW-1:0]     q,
                                                   input logic [AREA_W-1:0] d);
      logic [ACC_W-1:0] sh;
      logic [ACC_W-1:0] dz;
      logic             ge;
      sh = {acc[ACC_W-2:0], q[QW-1]};
      dz = ACC_W'(d);
      ge = sh >= dz;
      return {(ge ? sh - dz : sh), q[QW-2:0], ge};
   endfunction

   function automatic logic [ACC_W+QW-1:0] div_two(input logic [ACC_W-1:0]  acc,
                                                   input logic [QW-1:0]     q,
                                                   input logic [AREA_W-1:0] d);
      logic [ACC_W+QW-1:0] first;
      first = div_bit(acc, q, d);
      return div_bit(first[ACC_W+QW-1:QW], first[QW-1:0], d);
   endfunction

   always_comb begin
      nxt_r = div_two(acc_r_ff, q_r_ff, d_ff);
      nxt_g = div_two(acc_g_ff, q_g_ff, d_ff);
      nxt_b = div_two(acc_b_ff, q_b_ff, d_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         if (start) begin
            run_ff <= 1'b1;
         end else if (run_ff && cnt_ff == '0) begin
            run_ff  <= 1'b0;
            done_ff <= 1'b1;
         end else if (done_ff && take) begin
            done_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         d_ff         <= req.area;
         acc_r_ff     <= '0;
         acc_g_ff     <= '0;
         acc_b_ff     <= '0;
         q_r_ff       <= QW'(req.sum_r);
         q_g_ff       <= QW'(req.sum_g);
         q_b_ff       <= QW'(req.sum_b);
         row_end_ff   <= req.row_end;
         frame_end_ff <= req.frame_end;
         cnt_ff       <= CNT_W'(DIV_STEPS - 1);
      end else if (run_ff) begin
         {acc_r_ff, q_r_ff} <= nxt_r;
         {acc_g_ff, q_g_ff} <= nxt_g;
         {acc_b_ff, q_b_ff} <= nxt_b;
         if (cnt_ff != '0) begin
            cnt_ff <= cnt_ff - CNT_W'(1);
         end
      end
   end

   assign busy          = run_ff || done_ff;
   assign done          = done_ff;
   assign rsp.pixel     = {q_r_ff[RED_W-1:0], q_g_ff[GREEN_W-1:0], q_b_ff[BLUE_W-1:0]};
   assign rsp.row_end   = row_end_ff;
   assign rsp.frame_end = frame_end_ff;

endmodule

`default_nettype wire

// ===== rtl/core/rgb565_box_downscale.sv =====
// Box-filter downscaler for a raster stream of RGB565 pixels.
//
// Input pixels arrive on req_ (valid/stall) in raster order; req_frame_start
// marks the first pixel of a frame. Each output pixel leaves on rsp_ with
// row and frame end flags once the last pixel of its block has arrived.
// Registers are written through csr_we/csr_index/csr_wdata; the user must
// write them only while the block is idle, which the block does not enforce.
// A write recomputes the scale factors and holds req_stall meanwhile.
// Pixels that close no block are taken one per cycle while the scale unit and
// divider are idle: the line store is read on acceptance and written back in
// the next cycle, a forwarding register covering back-to-back pixels of the
// same column. A pixel that closes a block stalls the input until the
// averaging divider hands its result to the output register behind rsp_.
// A waiting result sits in the output register and does not block new
// pixels; only a second result waits in the divider, stalling the input.
// Reset clears the position counters, loads the default dimensions and
// computes the scale factors, stalling the input meanwhile. The line store
// is not cleared: each band's first row writes it before it is read.
`default_nettype none

module rgb565_box_downscale
   import rbd_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire logic [PIX_W-1:0] req_pixel_in,
   input  wire logic             req_frame_start,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output logic      [PIX_W-1:0] rsp_pixel_out,
   output logic                  rsp_row_end,
   output logic                  rsp_frame_end,
   input  wire logic             csr_we,
   input  wire logic [CSR_W-1:0] csr_index,
   input  wire logic [DIM_W-1:0] csr_wdata
);

   // configuration
   logic [DIM_W-1:0] iw_ff, ih_ff, ow_ff, oh_ff;
   scale_type        scale;

   // position counters
   logic [IN_W-1:0]  in_column_ff, in_column_in;
   logic [IN_W-1:0]  in_row_ff, in_row_in;
   logic [SUB_W-1:0] sub_column_ff, sub_column_in;
   logic [SUB_W-1:0] sub_row_ff, sub_row_in;
   logic [DIM_W-1:0] out_column_ff, out_column_in;
   logic [DIM_W-1:0] out_row_ff, out_row_in;

   // accept stage
   logic               req_xfer;
   logic [IN_W-1:0]    ic_c, ir_c;
   logic [SUB_W-1:0]   sc_c, sr_c;
   logic [DIM_W-1:0]   oc_c, or_c;
   logic [SCALE_W-1:0] sc_inc, sr_inc;
   logic               active, emit, first, rend, fend;

   // update stage
   logic               b_valid_ff;
   logic [COL_W-1:0]   b_idx_ff;
   logic [RED_W-1:0]   b_r_ff;
   logic [GREEN_W-1:0] b_g_ff;
   logic [BLUE_W-1:0]  b_b_ff;
   logic               b_first_ff, b_emit_ff, b_rend_ff, b_fend_ff;
   logic               fwd_valid_ff;
   logic [COL_W-1:0]   fwd_addr_ff;
   logic [SUM_W-1:0]   fwd_data_ff;
   logic [SUM_W-1:0]   ram_rd_data, old_sum, new_sum;
   logic [SUM_R_W-1:0] new_r;
   logic [SUM_G_W-1:0] new_g;
   logic [SUM_B_W-1:0] new_b;

   // divider and output
   div_req_type        div_req;
   div_rsp_type        div_rsp;
   logic               div_start, div_busy, div_done, div_take;
   logic               rsp_valid_ff;
   logic [PIX_W-1:0]   rsp_pixel_ff;
   logic               rsp_row_end_ff, rsp_frame_end_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         iw_ff <= IW_RESET;
         ih_ff <= IH_RESET;
         ow_ff <= OW_RESET;
         oh_ff <= OH_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_INPUT_WIDTH:   iw_ff <= clamp_dim(csr_wdata, DIM_W'(DIM_MAX));
            CSR_INPUT_HEIGHT:  ih_ff <= clamp_dim(csr_wdata, DIM_W'(DIM_MAX));
            CSR_OUTPUT_WIDTH:  ow_ff <= clamp_dim(csr_wdata, DIM_W'(OW_MAX));
            CSR_OUTPUT_HEIGHT: oh_ff <= clamp_dim(csr_wdata, DIM_W'(DIM_MAX));
            default:           iw_ff <= iw_ff;
         endcase
      end
   end

   rbd_scale_calc u_scale (
      .clock (clock),
      .reset (reset),
      .start (csr_we),
      .iw    (iw_ff),
      .ih    (ih_ff),
      .ow    (ow_ff),
      .oh    (oh_ff),
      .scale (scale)
   );

   assign req_stall = csr_we || scale.busy || div_busy || (b_valid_ff && b_emit_ff);
   assign req_xfer  = req_valid && !req_stall;

   always_comb begin
      ic_c = req_frame_start ? '0 : in_column_ff;
      ir_c = req_frame_start ? '0 : in_row_ff;
      sc_c = req_frame_start ? '0 : sub_column_ff;
      sr_c = req_frame_start ? '0 : sub_row_ff;
      oc_c = req_frame_start ? '0 : out_column_ff;
      or_c = req_frame_start ? '0 : out_row_ff;

      sc_inc = {1'b0, sc_c} + SCALE_W'(1);
      sr_inc = {1'b0, sr_c} + SCALE_W'(1);
      active = (oc_c < ow_ff) && (or_c < oh_ff);
      emit   = active && (sc_inc == scale.sx) && (sr_inc == scale.sy);
      first  = (sc_c == '0) && (sr_c == '0);
      rend   = (oc_c + DIM_W'(1)) == ow_ff;
      fend   = rend && ((or_c + DIM_W'(1)) == oh_ff);

      sub_column_in = sc_c;
      out_column_in = oc_c;
      if (active) begin
         if (sc_inc >= scale.sx) begin
            sub_column_in = '0;
            out_column_in = oc_c + DIM_W'(1);
         end else begin
            sub_column_in = sc_inc[SUB_W-1:0];
         end
      end

      in_column_in = ic_c + IN_W'(1);
      in_row_in    = ir_c;
      sub_row_in   = sr_c;
      out_row_in   = or_c;
      if ((DIM_W'(ic_c) + DIM_W'(1)) >= iw_ff) begin
         in_column_in  = '0;
         sub_column_in = '0;
         out_column_in = '0;
         if ((DIM_W'(ir_c) + DIM_W'(1)) >= ih_ff) begin
            in_row_in  = '0;
            sub_row_in = '0;
            out_row_in = '0;
         end else begin
            in_row_in = ir_c + IN_W'(1);
            if (or_c < oh_ff) begin
               if (sr_inc >= scale.sy) begin
                  sub_row_in = '0;
                  out_row_in = or_c + DIM_W'(1);
               end else begin
                  sub_row_in = sr_inc[SUB_W-1:0];
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_column_ff  <= '0;
         in_row_ff     <= '0;
         sub_column_ff <= '0;
         sub_row_ff    <= '0;
         out_column_ff <= '0;
         out_row_ff    <= '0;
         b_valid_ff    <= 1'b0;
         fwd_valid_ff  <= 1'b0;
      end else begin
         if (req_xfer) begin
            in_column_ff  <= in_column_in;
            in_row_ff     <= in_row_in;
            sub_column_ff <= sub_column_in;
            sub_row_ff    <= sub_row_in;
            out_column_ff <= out_column_in;
            out_row_ff    <= out_row_in;
         end
         b_valid_ff   <= req_xfer && active;
         fwd_valid_ff <= b_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         b_idx_ff   <= oc_c[COL_W-1:0];
         b_r_ff     <= req_pixel_in[RED_LSB +: RED_W];
         b_g_ff     <= req_pixel_in[GREEN_LSB +: GREEN_W];
         b_b_ff     <= req_pixel_in[BLUE_W-1:0];
         b_first_ff <= first;
         b_emit_ff  <= emit;
         b_rend_ff  <= rend;
         b_fend_ff  <= fend;
      end
      fwd_addr_ff <= b_idx_ff;
      fwd_data_ff <= new_sum;
   end

   rbd_band_ram u_ram (
      .clock   (clock),
      .rd_en   (req_xfer && active),
      .rd_addr (oc_c[COL_W-1:0]),
      .rd_data (ram_rd_data),
      .wr_en   (b_valid_ff),
      .wr_addr (b_idx_ff),
      .wr_data (new_sum)
   );

   // previous cycle's write is not yet visible at the read port
   always_comb begin
      old_sum = (fwd_valid_ff && fwd_addr_ff == b_idx_ff) ? fwd_data_ff : ram_rd_data;
      if (b_first_ff) begin
         new_r = SUM_R_W'(b_r_ff);
         new_g = SUM_G_W'(b_g_ff);
         new_b = SUM_B_W'(b_b_ff);
      end else begin
         new_r = old_sum[SUM_W-1 -: SUM_R_W] + SUM_R_W'(b_r_ff);
         new_g = old_sum[SUM_G_W+SUM_B_W-1 -: SUM_G_W] + SUM_G_W'(b_g_ff);
         new_b = old_sum[SUM_B_W-1:0] + SUM_B_W'(b_b_ff);
      end
      new_sum = {new_r, new_g, new_b};
   end

   assign div_start         = b_valid_ff && b_emit_ff;
   assign div_req.sum_r     = new_r;
   assign div_req.sum_g     = new_g;
   assign div_req.sum_b     = new_b;
   assign div_req.area      = scale.area;
   assign div_req.row_end   = b_rend_ff;
   assign div_req.frame_end = b_fend_ff;

   rbd_avg_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .req   (div_req),
      .take  (div_take),
      .busy  (div_busy),
      .done  (div_done),
      .rsp   (div_rsp)
   );

   assign div_take = div_done && (!rsp_valid_ff || !rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (div_take) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (div_take) begin
         rsp_pixel_ff     <= div_rsp.pixel;
         rsp_row_end_ff   <= div_rsp.row_end;
         rsp_frame_end_ff <= div_rsp.frame_end;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_pixel_out = rsp_pixel_ff;
   assign rsp_row_end   = rsp_row_end_ff;
   assign rsp_frame_end = rsp_frame_end_ff;

endmodule

`default_nettype wire

// ===== rtl/core/rbd_checker.sv =====
// Port-level assertions for the RGB565 box downscaler, bound to the top level.
`default_nettype none

module rbd_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_stall,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic [15:0] rsp_pixel_out,
   input wire logic        rsp_row_end,
   input wire logic        rsp_frame_end,
   input wire logic        csr_we
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_pixel_out)
         && $stable(rsp_row_end) && $stable(rsp_frame_end))
      else $error("result changed while stalled");

   a_frame_row: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_end |-> rsp_row_end)
      else $error("frame end without row end");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_stall)
      else $error("output valid or input open right after reset");

   a_cfg_stall: assert property (@(posedge clock)
      csr_we |-> req_stall ##1 req_stall)
      else $error("input open during scale recompute");

endmodule

bind rgb565_box_downscale rbd_checker u_checker (.*);

`default_nettype wire

// ===== sim/tb_top.sv =====
// Self-checking testbench for rgb565_box_downscale: framed pixel stimulus, box-average prediction.
module tb_top import rbd_pkg::*; ;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT   = 600000;
   localparam int SETTLE_CYCLES = 30;
   localparam int HOLD_CYCLES   = 400;
   localparam int RANDOM_ITEMS  = 1500;

   typedef struct packed {
      logic [PIX_W-1:0] pixel;
      logic             frame_start;
   } src_pixel_t;

   typedef struct packed {
      logic [PIX_W-1:0] pixel;
      logic             row_end;
      logic             frame_end;
   } scaled_pixel_t;

   typedef enum {PACE_FREE, PACE_LIGHT, PACE_HEAVY, PACE_BEAT} pace_t;

   logic             clock           = 1'b0;
   logic             reset           = 1'b1;
   logic             req_valid       = 1'b0;
   logic             req_stall;
   logic [PIX_W-1:0] req_pixel_in    = '0;
   logic             req_frame_start = 1'b0;
   logic             rsp_valid;
   logic             rsp_stall       = 1'b0;
   logic [PIX_W-1:0] rsp_pixel_out;
   logic             rsp_row_end;
   logic             rsp_frame_end;
   logic             csr_we          = 1'b0;
   logic [CSR_W-1:0] csr_index       = '0;
   logic [DIM_W-1:0] csr_wdata       = '0;

   src_pixel_t    pixels_pending[$];
   scaled_pixel_t averages_due[$];
   int            errors = 0;
   int            cycles = 0;

   // predictor copy of the dimension registers and position counters
   bit [DIM_W-1:0] dim_iw = 12'd640;
   bit [DIM_W-1:0] dim_ih = 12'd480;
   bit [DIM_W-1:0] dim_ow = 12'd240;
   bit [DIM_W-1:0] dim_oh = 12'd240;
   bit [11:0]      col_in, row_in, col_sub, row_sub, col_out, row_out;
   bit [13:0]      band_red   [MAX_WIDTH];
   bit [13:0]      band_green [MAX_WIDTH];
   bit [13:0]      band_blue  [MAX_WIDTH];

   int    burst_left = 8;
   int    gap_left = 0;
   bit    hold_request = 1'b0;
   bit    hold_taken = 1'b0;
   int    hold_left = 0;
   int    pace_left = 0;
   pace_t pace_mode = PACE_FREE;

   rgb565_box_downscale dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_pixel_in    (req_pixel_in),
      .req_frame_start (req_frame_start),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_pixel_out   (rsp_pixel_out),
      .rsp_row_end     (rsp_row_end),
      .rsp_frame_end   (rsp_frame_end),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always #2 clock = ~clock;

   function automatic int unsigned dim_eff(bit [DIM_W-1:0] v, int unsigned hi);
      if (v == 0) return 1;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic int unsigned box_span(int unsigned in_dim, int unsigned out_dim);
      int unsigned s;
      s = in_dim / out_dim;
      if (s < 1) s = 1;
      if (s > MAX_SCALE) s = MAX_SCALE;
      return s;
   endfunction

   function automatic void home_counters();
      col_in = 0;
      row_in = 0;
      col_sub = 0;
      row_sub = 0;
      col_out = 0;
      row_out = 0;
   endfunction

   task automatic box_average_step(input bit [PIX_W-1:0] pixel, input bit fs);
      int unsigned   iw, ih, ow, oh, sx, sy, area;
      scaled_pixel_t avg;
      iw = dim_eff(dim_iw, DIM_MAX);
      ih = dim_eff(dim_ih, DIM_MAX);
      ow = dim_eff(dim_ow, OW_MAX);
      oh = dim_eff(dim_oh, DIM_MAX);
      sx = box_span(iw, ow);
      sy = box_span(ih, oh);
      if (fs) home_counters();
      if (col_out < ow && row_out < oh) begin
         if (col_sub == 0 && row_sub == 0) begin
            band_red[col_out]   = pixel[15:11];
            band_green[col_out] = pixel[10:5];
            band_blue[col_out]  = pixel[4:0];
         end else begin
            band_red[col_out]   += pixel[15:11];
            band_green[col_out] += pixel[10:5];
            band_blue[col_out]  += pixel[4:0];
         end
         if (col_sub + 1 == sx && row_sub + 1 == sy) begin
            area = sx * sy;
            avg.pixel = {5'(band_red[col_out] / area), 6'(band_green[col_out] / area),
                         5'(band_blue[col_out] / area)};
            avg.row_end = (col_out + 1 == ow);
            avg.frame_end = avg.row_end && (row_out + 1 == oh);
            averages_due.push_back(avg);
         end
         if (col_sub + 1 >= sx) begin
            col_sub = 0;
            col_out = col_out + 1;
         end else begin
            col_sub = col_sub + 1;
         end
      end
      if (col_in + 1 >= iw) begin
         col_in = 0;
         col_sub = 0;
         col_out = 0;
         if (row_in + 1 >= ih) begin
            home_counters();
         end else begin
            row_in = row_in + 1;
            if (row_out < oh) begin
               if (row_sub + 1 >= sy) begin
                  row_sub = 0;
                  row_out = row_out + 1;
               end else begin
                  row_sub = row_sub + 1;
               end
            end
         end
      end else begin
         col_in = col_in + 1;
      end
   endtask

   // sender: bursts of random length separated by random gaps
   always @(posedge clock) begin : pixel_sender
      src_pixel_t nxt;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) box_average_step(req_pixel_in, req_frame_start);
         if (!req_valid || !req_stall) begin
            if (gap_left != 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pixels_pending.size() != 0) begin
               nxt = pixels_pending.pop_front();
               req_valid <= 1'b1;
               req_pixel_in <= nxt.pixel;
               req_frame_start <= nxt.frame_start;
               if (burst_left <= 1) begin
                  burst_left = $urandom_range(1, 32);
                  gap_left = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 8);
               end else begin
                  burst_left--;
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver stall pattern, plus one long hold-off on request
   always @(posedge clock) begin : receiver_pace
      logic stall_next;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (hold_request && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left != 0) begin
            hold_left--;
            stall_next = 1'b1;
         end else begin
            if (pace_left == 0) begin
               pace_mode = pace_t'($urandom_range(0, 3));
               pace_left = $urandom_range(50, 300);
            end else begin
               pace_left--;
            end
            case (pace_mode)
               PACE_FREE:  stall_next = 1'b0;
               PACE_LIGHT: stall_next = ($urandom_range(0, 3) == 0);
               PACE_HEAVY: stall_next = ($urandom_range(0, 3) != 0);
               default:    stall_next = ((pace_left / 3) % 2) == 1;
            endcase
         end
         rsp_stall <= stall_next;
      end
   end

   task automatic check_field(input string what, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin : result_monitor
      scaled_pixel_t want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (averages_due.size() == 0) begin
            $display("%0t ns: unexpected transfer, expected none, actual pixel %h", $time,
                     rsp_pixel_out);
            errors++;
         end else begin
            want = averages_due.pop_front();
            check_field("pixel_out", want.pixel, rsp_pixel_out);
            check_field("row_end", want.row_end, rsp_row_end);
            check_field("frame_end", want.frame_end, rsp_frame_end);
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("tb_top NOT OK");
         $finish;
      end
   end

   task automatic settle();
      do @(negedge clock);
      while (pixels_pending.size() != 0 || req_valid || averages_due.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_dim(input logic [CSR_W-1:0] idx, input logic [DIM_W-1:0] val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         CSR_INPUT_WIDTH:   dim_iw = val;
         CSR_INPUT_HEIGHT:  dim_ih = val;
         CSR_OUTPUT_WIDTH:  dim_ow = val;
         default:           dim_oh = val;
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic set_dims(input int unsigned iw, input int unsigned ih,
                           input int unsigned ow, input int unsigned oh);
      settle();
      write_dim(CSR_INPUT_WIDTH, iw);
      write_dim(CSR_INPUT_HEIGHT, ih);
      write_dim(CSR_OUTPUT_WIDTH, ow);
      write_dim(CSR_OUTPUT_HEIGHT, oh);
      @(negedge clock);
   endtask

   task automatic queue_pixel(input bit [PIX_W-1:0] p, input bit fs);
      src_pixel_t item;
      item.pixel = p;
      item.frame_start = fs;
      pixels_pending.push_back(item);
   endtask

   function automatic bit [PIX_W-1:0] random_pixel();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         default: return PIX_W'($urandom);
      endcase
   endfunction

   // whole, wrapped and cut-short frames; returns the count of pixels the block uses
   task automatic queue_scene(input int unsigned iw, input int unsigned ih,
                              input int unsigned ow, input int unsigned oh,
                              output int unsigned used);
      int unsigned span_w, span_h, frames, npix, c, r;
      bit          need_start, stray, fs;
      span_w = ow * box_span(iw, ow);
      span_h = oh * box_span(ih, oh);
      if (span_w > iw) span_w = iw;
      if (span_h > ih) span_h = ih;
      frames = $urandom_range(1, 3);
      need_start = 1'b1;
      used = 0;
      for (int f = 0; f < frames; f++) begin
         npix = iw * ih;
         stray = 1'b0;
         if ($urandom_range(0, 7) == 0) npix = $urandom_range(1, npix);
         for (int p = 0; p < npix; p++) begin
            if (p == 0) begin
               fs = need_start || $urandom_range(0, 1);
            end else begin
               fs = ($urandom_range(0, 199) == 0);
               stray |= fs;
            end
            c = p % iw;
            r = p / iw;
            if (c < span_w && r < span_h) used++;
            queue_pixel(random_pixel(), fs);
         end
         need_start = (npix != iw * ih) || stray;
      end
   endtask

   initial begin : stimulus
      int unsigned iw, ih, ow, oh, used, total;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // only the input width changes: reset heights give a vertical factor of 2,
      // output wider than input gives a horizontal factor of 1
      settle();
      write_dim(CSR_INPUT_WIDTH, 2);
      @(negedge clock);
      queue_pixel(16'hFFFF, 1'b1);
      queue_pixel(16'h0000, 1'b0);
      queue_pixel(16'hF800, 1'b0);
      queue_pixel(16'h07FF, 1'b0);

      // zero registers act as 1: every pixel is a whole frame
      set_dims(0, 0, 0, 0);
      queue_pixel(16'h0000, 1'b1);
      queue_pixel(16'hFFFF, 1'b0);
      queue_pixel(random_pixel(), 1'b0);

      // oversized registers clamp to 2048
      set_dims(12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF);
      queue_pixel(16'h07E0, 1'b1);
      queue_pixel(16'h001F, 1'b0);

      // horizontal factor saturates at MAX_SCALE, full-scale sums, one excess column
      set_dims(17, 1, 1, 1);
      for (int i = 0; i < 17; i++) queue_pixel(16'hFFFF, i == 0);

      // one result per pixel while the receiver holds off
      set_dims(8, 8, 8, 8);
      hold_request = 1'b1;
      for (int i = 0; i < 64; i++) queue_pixel(random_pixel(), i == 0);
      total = 64;

      while (total < RANDOM_ITEMS) begin
         ow = $urandom_range(1, 6);
         iw = ow * $urandom_range(1, 4) + $urandom_range(0, 2);
         oh = $urandom_range(1, 4);
         ih = oh * $urandom_range(1, 4) + $urandom_range(0, 2);
         case ($urandom_range(0, 9))
            0: ow = iw + $urandom_range(1, 3);
            1: oh = ih + $urandom_range(1, 2);
            2: begin
               ow = 1;
               iw = $urandom_range(16, 19);
               oh = $urandom_range(1, 2);
               ih = oh * $urandom_range(1, 2);
            end
            default: ;
         endcase
         set_dims(iw, ih, ow, oh);
         queue_scene(iw, ih, ow, oh, used);
         total += used;
      end

      settle();
      if (errors == 0) begin
         $display("tb_top OK");
      end else begin
         $display("tb_top NOT OK");
      end
      $finish;
   end

endmodule
